@@ rtl/core/owm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// One-wire master package
// Shared types, codes and reset values of the one-wire slot engine.
// ----------------------------------------------------------------------------
package owm_pkg;

    localparam int TIMER_WIDTH_DEF = 10;
    localparam int CFG_W           = 10;
    localparam int CFG_IDX_W       = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_TAIL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_SLOT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_TAIL     = 3'd6;

    localparam logic [CFG_W-1:0] DEF_RESET_LOW     = 10'd480;
    localparam logic [CFG_W-1:0] DEF_PRESENCE_WAIT = 10'd60;
    localparam logic [CFG_W-1:0] DEF_RESET_TAIL    = 10'd420;
    localparam logic [CFG_W-1:0] DEF_SLOT_LOW      = 10'd1;
    localparam logic [CFG_W-1:0] DEF_WRITE_SLOT    = 10'd60;
    localparam logic [CFG_W-1:0] DEF_READ_SAMPLE   = 10'd14;
    localparam logic [CFG_W-1:0] DEF_READ_TAIL     = 10'd45;

    localparam logic [3:0] BITS_BYTE = 4'd8;
    localparam logic [3:0] BITS_ONE  = 4'd1;

    typedef enum logic [2:0] {
        OP_RESET = 3'd0,
        OP_WBIT  = 3'd1,
        OP_RBIT  = 3'd2,
        OP_WBYTE = 3'd3,
        OP_RBYTE = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_LOW    = 3'd1,
        PH_WRITE  = 3'd2,
        PH_WAIT   = 3'd3,
        PH_SAMPLE = 3'd4,
        PH_TAIL   = 3'd5
    } t_phase;

    typedef struct packed {
        logic [CFG_W-1:0] reset_low_ticks;
        logic [CFG_W-1:0] presence_wait_ticks;
        logic [CFG_W-1:0] reset_tail_ticks;
        logic [CFG_W-1:0] slot_low_ticks;
        logic [CFG_W-1:0] write_slot_ticks;
        logic [CFG_W-1:0] read_sample_ticks;
        logic [CFG_W-1:0] read_tail_ticks;
    } t_cfg;

    typedef struct packed {
        logic       start_req;
        logic [2:0] operation;
        logic [7:0] data_byte;
        logic       line_in;
    } t_in_word;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence_fault;
        logic [7:0] read_data;
    } t_out_word;

endpackage
`default_nettype wire

@@ rtl/core/owm_tick_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// One-wire slot sequencer
// Holds the slot state and works out one microsecond tick per enabled cycle.
// ----------------------------------------------------------------------------
module owm_tick_core
    import owm_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_en,
    input  wire t_cfg      i_cfg,
    input  wire t_in_word  i_word,
    output t_out_word      o_res
);

    localparam int LW = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

    typedef struct packed {
        t_phase                 phase;
        logic [TIMER_WIDTH-1:0] tick;
        logic [3:0]             bits;
        logic [7:0]             sh;
        t_op                    op;
        logic                   done;
    } t_st;

    t_st  r_st;
    t_st  n_st;
    logic r_presence;
    logic n_presence;

    function automatic logic [TIMER_WIDTH-1:0] f_load(input logic [CFG_W-1:0] v);
        logic [LW-1:0] v_ext;
        logic [LW-1:0] t_max;
        v_ext = LW'(v);
        t_max = LW'({TIMER_WIDTH{1'b1}});
        return TIMER_WIDTH'((v_ext > t_max) ? t_max : v_ext);
    endfunction

    function automatic logic f_is_write(input t_op op);
        return (op == OP_WBIT) || (op == OP_WBYTE);
    endfunction

    function automatic t_st f_enter(input t_st s, input t_phase ph, input t_cfg c);
        t_st  r;
        logic rst;
        r       = s;
        rst     = (s.op == OP_RESET);
        r.phase = ph;
        case (ph)
            PH_LOW:    r.tick = f_load(rst ? c.reset_low_ticks : c.slot_low_ticks);
            PH_WRITE:  r.tick = f_load(c.write_slot_ticks);
            PH_WAIT:   r.tick = f_load(rst ? c.presence_wait_ticks : c.read_sample_ticks);
            PH_SAMPLE: r.tick = TIMER_WIDTH'(1);
            PH_TAIL:   r.tick = f_load(rst ? c.reset_tail_ticks : c.read_tail_ticks);
            default:   r.tick = '0;
        endcase
        return r;
    endfunction

    function automatic t_st f_finish(input t_st s);
        t_st r;
        r       = s;
        r.phase = PH_IDLE;
        r.tick  = '0;
        r.done  = 1'b1;
        return r;
    endfunction

    function automatic t_st f_bit_end(input t_st s, input t_cfg c);
        t_st r;
        r = s;
        if (f_is_write(s.op)) begin
            r.sh = s.sh >> 1;
        end
        r.bits = s.bits - 4'd1;
        if (r.bits == 4'd0) begin
            r = f_finish(r);
        end else begin
            r = f_enter(r, PH_LOW, c);
        end
        return r;
    endfunction

    function automatic t_st f_step(input t_st s, input t_cfg c);
        t_st r;
        r = s;
        if (s.phase != PH_IDLE && s.tick == '0) begin
            case (s.phase)
                PH_LOW:    r = f_enter(s, f_is_write(s.op) ? PH_WRITE : PH_WAIT, c);
                PH_WRITE:  r = f_bit_end(s, c);
                PH_WAIT:   r = f_enter(s, PH_SAMPLE, c);
                PH_SAMPLE: r = f_enter(s, PH_TAIL, c);
                PH_TAIL:   r = (s.op == OP_RESET) ? f_finish(s) : f_bit_end(s, c);
                default:   r = f_finish(s);
            endcase
        end
        return r;
    endfunction

    // Every expired phase is closed in the same tick. A write with zero-length
    // low and slot times runs out all its remaining bits at once; any other
    // chain reaches a nonzero timer or the sample phase within four steps.
    function automatic t_st f_settle(input t_st s, input t_cfg c);
        t_st r;
        r = s;
        if (f_is_write(s.op) && s.tick == '0
                && (s.phase == PH_LOW || s.phase == PH_WRITE)
                && c.slot_low_ticks == '0 && c.write_slot_ticks == '0) begin
            r.sh   = s.sh >> s.bits;
            r.bits = 4'd0;
            r      = f_finish(r);
        end else begin
            for (int k = 0; k < 4; k++) begin
                r = f_step(r, c);
            end
        end
        return r;
    endfunction

    always_comb begin
        t_st  s;
        logic busy;
        logic drive;
        s          = r_st;
        s.done     = 1'b0;
        busy       = 1'b0;
        drive      = 1'b0;
        n_presence = r_presence;
        if (s.phase == PH_IDLE && i_word.start_req && i_word.operation <= OP_RBYTE) begin
            s.op   = t_op'(i_word.operation);
            s.sh   = i_word.data_byte;
            s.bits = (s.op == OP_WBYTE || s.op == OP_RBYTE) ? BITS_BYTE : BITS_ONE;
            s      = f_enter(s, PH_LOW, i_cfg);
            busy   = 1'b1;
            s      = f_settle(s, i_cfg);
        end else if (s.phase != PH_IDLE) begin
            busy = 1'b1;
        end
        if (s.phase != PH_IDLE) begin
            case (s.phase)
                PH_LOW:   drive = 1'b1;
                PH_WRITE: drive = ~s.sh[0];
                PH_SAMPLE: begin
                    if (s.op == OP_RESET) begin
                        n_presence = i_word.line_in;
                    end else if (s.op == OP_RBIT) begin
                        s.sh = {7'd0, i_word.line_in};
                    end else begin
                        s.sh = {i_word.line_in, s.sh[7:1]};
                    end
                end
                default: drive = 1'b0;
            endcase
            s.tick = s.tick - 1'b1;
            if (s.tick == '0) begin
                s = f_settle(s, i_cfg);
            end
        end
        n_st                 = s;
        o_res.drive_low      = drive;
        o_res.busy_res       = busy;
        o_res.done_res       = s.done;
        o_res.presence_fault = n_presence;
        o_res.read_data      = (s.op == OP_RBIT || s.op == OP_RBYTE) ? s.sh : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase <= PH_IDLE;
            r_st.tick  <= '0;
            r_st.bits  <= '0;
            r_st.sh    <= '0;
            r_st.op    <= OP_RESET;
            r_st.done  <= 1'b0;
            r_presence <= 1'b0;
        end else if (i_en) begin
            r_st       <= n_st;
            r_presence <= n_presence;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/onewire_master_slot_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// One-wire bus master slot engine
// Reset/presence, bit and byte slots on an open-drain single-wire bus,
// timed by one input word per microsecond tick.
// ----------------------------------------------------------------------------
//  Channel   Signals                               Word
//  input     i_in_valid, o_in_stall, i_in_word     one tick: request, line level
//  output    o_out_valid, i_out_stall, o_out_word  drive, busy, done, fault, data
//  config    i_cfg_we, i_cfg_idx, i_cfg_data       one timing register
//
// One word is taken every cycle while the input is not stalled; its result is
// presented after passing an input register and a result register.
// The slot state advances by one tick as each word moves into the result register.
// Reset loads the default timing and leaves the engine idle.
// A stall on the output holds the result register and, once the input register
// is full, stalls the input.
// ----------------------------------------------------------------------------
module onewire_master_slot_engine
    import owm_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_word             i_in_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_word                 o_out_word,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg      r_cfg;
    t_in_word  r_in;
    logic      r_in_vld;
    t_out_word r_out;
    logic      r_out_vld;
    t_out_word w_res;
    logic      w_adv;

    assign w_adv       = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall  = r_in_vld && !w_adv;
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_ticks     <= DEF_RESET_LOW;
            r_cfg.presence_wait_ticks <= DEF_PRESENCE_WAIT;
            r_cfg.reset_tail_ticks    <= DEF_RESET_TAIL;
            r_cfg.slot_low_ticks      <= DEF_SLOT_LOW;
            r_cfg.write_slot_ticks    <= DEF_WRITE_SLOT;
            r_cfg.read_sample_ticks   <= DEF_READ_SAMPLE;
            r_cfg.read_tail_ticks     <= DEF_READ_TAIL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RESET_LOW:     r_cfg.reset_low_ticks     <= i_cfg_data;
                CFG_PRESENCE_WAIT: r_cfg.presence_wait_ticks <= i_cfg_data;
                CFG_RESET_TAIL:    r_cfg.reset_tail_ticks    <= i_cfg_data;
                CFG_SLOT_LOW:      r_cfg.slot_low_ticks      <= i_cfg_data;
                CFG_WRITE_SLOT:    r_cfg.write_slot_ticks    <= i_cfg_data;
                CFG_READ_SAMPLE:   r_cfg.read_sample_ticks   <= i_cfg_data;
                CFG_READ_TAIL:     r_cfg.read_tail_ticks     <= i_cfg_data;
                default:           r_cfg                     <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_word;
        end
    end

    owm_tick_core #(
        .TIMER_WIDTH(TIMER_WIDTH)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_adv),
        .i_cfg  (r_cfg),
        .i_word (r_in),
        .o_res  (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.done_res) |-> o_out_word.busy_res)
        else $error("Completion reported on a word that is not busy.");

    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.drive_low) |-> o_out_word.busy_res)
        else $error("Bus driven low outside a command.");

    a_in_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_in_vld)
        else $error("Accepted word lost before the input register.");

endmodule
`default_nettype wire

@@ dv/onewire_master_slot_engine_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// One-wire slot engine testbench
// Feeds tick words carrying commands and line levels, predicts every result
// word with a tick-true model of the slot timing, and compares each field.
// Covers default, all-zero and six small random timing settings,
// with random idling on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
module onewire_master_slot_engine_tb;
    import owm_pkg::*;

    localparam int TW          = TIMER_WIDTH_DEF;
    localparam logic [TW-1:0] TICK_MAX = '1;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int LINE_RANDOM = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    logic                 clk;
    logic                 rst_n    = 1'b0;
    logic                 in_valid = 1'b0;
    t_in_word             in_word  = '0;
    logic                 in_stall;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_word            out_word;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    onewire_master_slot_engine dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    t_cfg          timing;
    t_phase        eng_ph;
    logic [TW-1:0] eng_ticks;
    logic [3:0]    eng_bits;
    logic [7:0]    eng_shift;
    t_op           eng_op;
    logic          eng_presence;
    logic          eng_done;

    t_in_word  tick_backlog[$];
    t_out_word tick_results_due[$];

    int err_cnt       = 0;
    int words_checked = 0;
    int cmds_done     = 0;
    int settings_cnt  = 0;
    int cycle_cnt     = 0;
    int send_gap      = 0;
    int stall_left    = 0;
    int hold_left     = 0;
    int hold_ask      = 0;
    int hold_seen     = 0;
    bit quiet         = 1'b0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void enter_phase(t_phase p);
        logic [CFG_W-1:0] len;
        len = '0;
        eng_ph = p;
        case (p)
            PH_LOW: begin
                len = (eng_op == OP_RESET) ? timing.reset_low_ticks : timing.slot_low_ticks;
            end
            PH_WRITE: begin
                len = timing.write_slot_ticks;
            end
            PH_WAIT: begin
                len = (eng_op == OP_RESET) ? timing.presence_wait_ticks
                                           : timing.read_sample_ticks;
            end
            PH_SAMPLE: begin
                len = CFG_W'(1);
            end
            PH_TAIL: begin
                len = (eng_op == OP_RESET) ? timing.reset_tail_ticks : timing.read_tail_ticks;
            end
            default: begin
                len = '0;
            end
        endcase
        eng_ticks = (len > TICK_MAX) ? TICK_MAX : TW'(len);
    endfunction

    function automatic void cmd_done();
        eng_ph    = PH_IDLE;
        eng_ticks = '0;
        eng_done  = 1'b1;
    endfunction

    function automatic void bit_end();
        if (eng_op == OP_WBIT || eng_op == OP_WBYTE) begin
            eng_shift = eng_shift >> 1;
        end
        eng_bits = eng_bits - 4'd1;
        if (eng_bits == 4'd0) begin
            cmd_done();
        end else begin
            enter_phase(PH_LOW);
        end
    endfunction

    function automatic void phase_end();
        case (eng_ph)
            PH_LOW: begin
                if (eng_op == OP_WBIT || eng_op == OP_WBYTE) begin
                    enter_phase(PH_WRITE);
                end else begin
                    enter_phase(PH_WAIT);
                end
            end
            PH_WRITE: begin
                bit_end();
            end
            PH_WAIT: begin
                enter_phase(PH_SAMPLE);
            end
            PH_SAMPLE: begin
                enter_phase(PH_TAIL);
            end
            PH_TAIL: begin
                if (eng_op == OP_RESET) begin
                    cmd_done();
                end else begin
                    bit_end();
                end
            end
            default: begin
                cmd_done();
            end
        endcase
    endfunction

    function automatic void settle();
        while (eng_ph != PH_IDLE && eng_ticks == '0) begin
            phase_end();
        end
    endfunction

    // Advances the slot engine by one tick and returns the word it reports.
    function automatic t_out_word engine_step(t_in_word w);
        t_out_word r;
        r = '0;
        eng_done = 1'b0;
        if (eng_ph == PH_IDLE && w.start_req && w.operation <= OP_RBYTE) begin
            eng_op    = t_op'(w.operation);
            eng_shift = w.data_byte;
            eng_bits  = (eng_op == OP_WBYTE || eng_op == OP_RBYTE) ? BITS_BYTE : BITS_ONE;
            enter_phase(PH_LOW);
            r.busy_res = 1'b1;
            settle();
        end else if (eng_ph != PH_IDLE) begin
            r.busy_res = 1'b1;
        end
        if (eng_ph != PH_IDLE) begin
            case (eng_ph)
                PH_LOW: begin
                    r.drive_low = 1'b1;
                end
                PH_WRITE: begin
                    r.drive_low = ~eng_shift[0];
                end
                PH_SAMPLE: begin
                    if (eng_op == OP_RESET) begin
                        eng_presence = w.line_in;
                    end else if (eng_op == OP_RBIT) begin
                        eng_shift = {7'd0, w.line_in};
                    end else begin
                        eng_shift = {w.line_in, eng_shift[7:1]};
                    end
                end
                default: begin
                end
            endcase
            eng_ticks = eng_ticks - 1'b1;
            if (eng_ticks == '0) begin
                phase_end();
                settle();
            end
        end
        r.done_res       = eng_done;
        r.presence_fault = eng_presence;
        r.read_data      = (eng_op == OP_RBIT || eng_op == OP_RBYTE) ? eng_shift : 8'h00;
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            err_cnt++;
        end
    endfunction

    function automatic logic pick_line(int lvl);
        return (lvl == LINE_RANDOM) ? 1'($urandom_range(0, 1)) : 1'(lvl);
    endfunction

    function automatic void push_tick(logic start, logic [2:0] op, logic [7:0] data,
                                      logic line);
        t_in_word w;
        w.start_req = start;
        w.operation = op;
        w.data_byte = data;
        w.line_in   = line;
        tick_backlog.push_back(w);
    endfunction

    // Sender side.
    always @(posedge clk) begin
        logic     nxt_valid;
        t_in_word nxt_word;
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_word  <= '0;
        end else begin
            nxt_valid = in_valid;
            nxt_word  = in_word;
            if (in_valid && !in_stall) begin
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (tick_backlog.size() != 0) begin
                    nxt_word  = tick_backlog.pop_front();
                    nxt_valid = 1'b1;
                    if (!quiet && $urandom_range(0, 15) == 0) begin
                        send_gap = $urandom_range(1, 13);
                    end
                end
            end
            in_valid <= nxt_valid;
            in_word  <= nxt_word;
        end
    end

    // Receiver side.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (hold_seen != hold_ask) begin
            hold_seen = hold_ask;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(0, 12);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        t_out_word want;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                tick_results_due.push_back(engine_step(in_word));
            end
            if (out_valid && !out_stall) begin
                if (tick_results_due.size() == 0) begin
                    $error("Result word arrived with no tick outstanding.");
                    err_cnt++;
                end else begin
                    want = tick_results_due.pop_front();
                    check_field("drive_low", 8'(want.drive_low), 8'(out_word.drive_low));
                    check_field("busy_res", 8'(want.busy_res), 8'(out_word.busy_res));
                    check_field("done_res", 8'(want.done_res), 8'(out_word.done_res));
                    check_field("presence_fault", 8'(want.presence_fault),
                                8'(out_word.presence_fault));
                    check_field("read_data", want.read_data, out_word.read_data);
                    words_checked++;
                    if (want.done_res) begin
                        cmds_done++;
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Run timed out after %0d cycles.", cycle_cnt);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic drain();
        @(negedge clk);
        while (tick_backlog.size() != 0 || in_valid || tick_results_due.size() != 0) begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic finish_cmd(int lvl);
        drain();
        while (eng_ph != PH_IDLE) begin
            repeat (32) push_tick(1'b0, 3'($urandom), 8'($urandom), pick_line(lvl));
            drain();
        end
    endtask

    task automatic run_cmd(t_op op, logic [7:0] data, int lvl);
        push_tick(1'b1, op, data, pick_line(lvl));
        // A second request straight after is ignored if the first is still running.
        push_tick(1'b1, OP_WBYTE, ~data, pick_line(lvl));
        finish_cmd(lvl);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_RESET_LOW:     timing.reset_low_ticks     = val;
            CFG_PRESENCE_WAIT: timing.presence_wait_ticks = val;
            CFG_RESET_TAIL:    timing.reset_tail_ticks    = val;
            CFG_SLOT_LOW:      timing.slot_low_ticks      = val;
            CFG_WRITE_SLOT:    timing.write_slot_ticks    = val;
            CFG_READ_SAMPLE:   timing.read_sample_ticks   = val;
            CFG_READ_TAIL:     timing.read_tail_ticks     = val;
            default: begin
            end
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_timing(t_cfg c);
        cfg_write(CFG_RESET_LOW, c.reset_low_ticks);
        cfg_write(CFG_PRESENCE_WAIT, c.presence_wait_ticks);
        cfg_write(CFG_RESET_TAIL, c.reset_tail_ticks);
        cfg_write(CFG_SLOT_LOW, c.slot_low_ticks);
        cfg_write(CFG_WRITE_SLOT, c.write_slot_ticks);
        cfg_write(CFG_READ_SAMPLE, c.read_sample_ticks);
        cfg_write(CFG_READ_TAIL, c.read_tail_ticks);
        settings_cnt++;
    endtask

    initial begin
        t_cfg c;
        int   p;
        int   k;
        timing = {DEF_RESET_LOW, DEF_PRESENCE_WAIT, DEF_RESET_TAIL, DEF_SLOT_LOW,
                  DEF_WRITE_SLOT, DEF_READ_SAMPLE, DEF_READ_TAIL};
        eng_ph       = PH_IDLE;
        eng_ticks    = '0;
        eng_bits     = '0;
        eng_shift    = '0;
        eng_op       = OP_RESET;
        eng_presence = 1'b0;
        eng_done     = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Default timing first, then unused operation codes which must be ignored.
        settings_cnt++;
        for (k = OP_SPARE_LO; k <= OP_SPARE_HI; k++) begin
            push_tick(1'b1, 3'(k), 8'($urandom), 1'b0);
        end
        push_tick(1'b0, OP_RESET, 8'h00, 1'b1);
        run_cmd(OP_WBIT, 8'hFE, 1);
        run_cmd(OP_RBIT, 8'h5A, LINE_RANDOM);

        // With all waits zero, all but byte reads end on their accepting tick.
        c = '0;
        load_timing(c);
        run_cmd(OP_RESET, 8'h00, 1);
        run_cmd(OP_WBIT, 8'h00, 0);
        run_cmd(OP_RBIT, 8'hFF, 1);
        run_cmd(OP_WBYTE, 8'h3C, 0);
        run_cmd(OP_RBYTE, 8'h00, LINE_RANDOM);
        push_tick(1'b1, OP_RBYTE, 8'hC3, 1'b1);
        push_tick(1'b1, OP_WBYTE, 8'h3C, 1'b0);
        push_tick(1'b1, OP_RESET, 8'h00, 1'b1);
        finish_cmd(LINE_RANDOM);

        // A write to the unused index must leave the timing alone.
        cfg_write(CFG_NONE, '1);
        run_cmd(OP_RESET, 8'h00, 0);
        run_cmd(OP_RBYTE, 8'h00, LINE_RANDOM);

        for (p = 0; p < 6; p++) begin
            k = (p == 2) ? 24 : 6;
            c.reset_low_ticks     = CFG_W'($urandom_range(0, k));
            c.presence_wait_ticks = CFG_W'($urandom_range(0, k));
            c.reset_tail_ticks    = CFG_W'($urandom_range(0, k));
            c.slot_low_ticks      = CFG_W'($urandom_range(0, k));
            c.write_slot_ticks    = CFG_W'($urandom_range(0, k));
            c.read_sample_ticks   = CFG_W'($urandom_range(0, k));
            c.read_tail_ticks     = CFG_W'($urandom_range(0, k));
            load_timing(c);
            if (p == 3) begin
                hold_ask++;
            end
            if (p == 5) begin
                quiet = 1'b1;
            end
            repeat (225) begin
                if ($urandom_range(0, 3) == 0) begin
                    push_tick(1'b1, ($urandom_range(0, 15) == 0)
                                    ? 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI))
                                    : 3'($urandom_range(OP_RESET, OP_RBYTE)),
                              8'($urandom), 1'($urandom));
                end else begin
                    push_tick(1'b0, 3'($urandom), 8'($urandom), 1'($urandom));
                end
            end
            finish_cmd(LINE_RANDOM);
        end

        repeat (8) @(negedge clk);
        if (tick_results_due.size() != 0) begin
            $error("%0d result words never arrived.", tick_results_due.size());
            err_cnt++;
        end
        $display("Ran %0d timing settings; %0d result words checked, %0d commands completed.",
                 settings_cnt, words_checked, cmds_done);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ filelist.f @@
rtl/core/owm_pkg.sv
rtl/core/owm_tick_core.sv
rtl/core/onewire_master_slot_engine.sv
dv/onewire_master_slot_engine_tb.sv
